// ===== hdl/dovj_pkg.sv =====
// ----------------------------------------------------------------------------
// dovj_pkg: shared types and constants for the date offset unit
// Pipeline depths, day-number constants, reciprocal multipliers for the
// constant divisions and the small month tables of the Meeus method.
// ----------------------------------------------------------------------------
package dovj_pkg;

  // Pipeline depth of the two halves.
  localparam int unsigned FWD_STAGES  = 3;
  localparam int unsigned INV_STAGES  = 7;
  localparam int unsigned PIPE_STAGES = FWD_STAGES + INV_STAGES;

  typedef logic [FWD_STAGES-1:0] fwd_ld_t;
  typedef logic [INV_STAGES-1:0] inv_ld_t;

  // Day numbers of 0001-01-01 and 9999-12-31.
  localparam logic signed [24:0] JDN_FIRST = 25'sd1721426;
  localparam logic signed [24:0] JDN_LAST  = 25'sd5373484;

  localparam int unsigned YEAR_BIAS = 4716;

  // floor(n / 100) for n below 2^15: n * RCP >> SH.
  localparam int unsigned DIV100_SH = 22;
  localparam logic [15:0] DIV100_RCP =
    16'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);

  // floor(n / 146097) for n below 2^24.
  localparam int unsigned DIVB_SH = 42;
  localparam logic [24:0] DIVB_RCP =
    25'(((64'd1 << DIVB_SH) + 64'd146096) / 64'd146097);

  // floor(n / 7305) for n below 2^27.
  localparam int unsigned DIVE_SH = 40;
  localparam logic [27:0] DIVE_RCP =
    28'(((64'd1 << DIVE_SH) + 64'd7304) / 64'd7305);

  // Smallest day-of-year remainder for which floor(10000 * h / 306001) >= k.
  localparam logic [9:0] G_THR [16] = '{
    10'd0,
    10'((306001 *  1 + 9999) / 10000), 10'((306001 *  2 + 9999) / 10000),
    10'((306001 *  3 + 9999) / 10000), 10'((306001 *  4 + 9999) / 10000),
    10'((306001 *  5 + 9999) / 10000), 10'((306001 *  6 + 9999) / 10000),
    10'((306001 *  7 + 9999) / 10000), 10'((306001 *  8 + 9999) / 10000),
    10'((306001 *  9 + 9999) / 10000), 10'((306001 * 10 + 9999) / 10000),
    10'((306001 * 11 + 9999) / 10000), 10'((306001 * 12 + 9999) / 10000),
    10'((306001 * 13 + 9999) / 10000), 10'((306001 * 14 + 9999) / 10000),
    10'((306001 * 15 + 9999) / 10000)
  };

  // floor(30.6001 * (m + 1)) for the raw month code, where January and
  // February count as months 13 and 14 of the year before.
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] t;
    unique case (m)
      4'd0:    t = 9'((306001 * 13) / 10000);
      4'd1:    t = 9'((306001 * 14) / 10000);
      4'd2:    t = 9'((306001 * 15) / 10000);
      4'd3:    t = 9'((306001 *  4) / 10000);
      4'd4:    t = 9'((306001 *  5) / 10000);
      4'd5:    t = 9'((306001 *  6) / 10000);
      4'd6:    t = 9'((306001 *  7) / 10000);
      4'd7:    t = 9'((306001 *  8) / 10000);
      4'd8:    t = 9'((306001 *  9) / 10000);
      4'd9:    t = 9'((306001 * 10) / 10000);
      4'd10:   t = 9'((306001 * 11) / 10000);
      4'd11:   t = 9'((306001 * 12) / 10000);
      4'd12:   t = 9'((306001 * 13) / 10000);
      4'd13:   t = 9'((306001 * 14) / 10000);
      4'd14:   t = 9'((306001 * 15) / 10000);
      default: t = 9'((306001 * 16) / 10000);
    endcase
    return t;
  endfunction

  // floor(30.6001 * g), the day offset at which month code g begins.
  function automatic logic [9:0] month_base(input logic [3:0] g);
    logic [9:0] t;
    unique case (g)
      4'd0:    t = 10'd0;
      4'd1:    t = 10'((306001 *  1) / 10000);
      4'd2:    t = 10'((306001 *  2) / 10000);
      4'd3:    t = 10'((306001 *  3) / 10000);
      4'd4:    t = 10'((306001 *  4) / 10000);
      4'd5:    t = 10'((306001 *  5) / 10000);
      4'd6:    t = 10'((306001 *  6) / 10000);
      4'd7:    t = 10'((306001 *  7) / 10000);
      4'd8:    t = 10'((306001 *  8) / 10000);
      4'd9:    t = 10'((306001 *  9) / 10000);
      4'd10:   t = 10'((306001 * 10) / 10000);
      4'd11:   t = 10'((306001 * 11) / 10000);
      4'd12:   t = 10'((306001 * 12) / 10000);
      4'd13:   t = 10'((306001 * 13) / 10000);
      4'd14:   t = 10'((306001 * 14) / 10000);
      default: t = 10'((306001 * 15) / 10000);
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/dovj_fwd.sv =====
// ----------------------------------------------------------------------------
// dovj_fwd: date to Julian day number, plus offset
// Three register stages: year adjust and month term, century quotient and
// year term, then the final sum with the Gregorian correction.
// ----------------------------------------------------------------------------
module dovj_fwd (
  input  logic                clk,
  input  dovj_pkg::fwd_ld_t   ld,
  input  logic [4:0]          day,
  input  logic [3:0]          month,
  input  logic [13:0]         year,
  input  logic signed [22:0]  offset_days,
  output logic signed [24:0]  jdn
);
  import dovj_pkg::*;

  // Stage 1
  logic              dec;
  logic [14:0]       yp_nxt, yp_r;
  logic [14:0]       yt_nxt, yt_r;
  logic [8:0]        tm_r;
  logic [4:0]        d1_r;
  logic signed [22:0] off1_r;

  // January and February belong to the year before.
  assign dec    = (month < 4'd3);
  assign yp_nxt = {1'b0, year} + 15'd100 - {14'b0, dec};
  assign yt_nxt = {1'b0, year} + 15'(YEAR_BIAS) - {14'b0, dec};

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      yp_r   <= yp_nxt;
      yt_r   <= yt_nxt;
      tm_r   <= month_term(month);
      d1_r   <= day;
      off1_r <= offset_days;
    end
  end

  // Stage 2
  logic [30:0]        cq_prod;
  logic [24:0]        t1_prod;
  logic signed [8:0]  cent_nxt, cent_r;
  logic [22:0]        t1_nxt, t1_r;
  logic signed [23:0] part_nxt, part_r;

  // The year was biased by 100 so the century quotient stays non-negative.
  assign cq_prod  = 31'(yp_r) * 31'(DIV100_RCP);
  assign cent_nxt = $signed(9'(cq_prod >> DIV100_SH) - 9'd1);
  assign t1_prod  = 25'(yt_r) * 25'(11'd1461);
  assign t1_nxt   = t1_prod[24:2];
  assign part_nxt = 24'(off1_r) + $signed({15'b0, tm_r}) + $signed({19'b0, d1_r})
                    - 24'sd1524;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      cent_r <= cent_nxt;
      t1_r   <= t1_nxt;
      part_r <= part_nxt;
    end
  end

  // Stage 3
  logic signed [9:0]  gcorr;
  logic signed [24:0] jdn_nxt, jdn_r;

  assign gcorr   = 10'sd2 - 10'(cent_r) + 10'(cent_r >>> 2);
  assign jdn_nxt = $signed({2'b0, t1_r}) + 25'(part_r) + 25'(gcorr);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      jdn_r <= jdn_nxt;
    end
  end

  assign jdn = jdn_r;

endmodule

// ===== hdl/dovj_inv.sv =====
// ----------------------------------------------------------------------------
// dovj_inv: Julian day number back to a Gregorian date
// Seven register stages: range test, century quotient, day count, year
// quotient, day of year, month search and the final output register.
// ----------------------------------------------------------------------------
module dovj_inv (
  input  logic               clk,
  input  dovj_pkg::inv_ld_t  ld,
  input  logic signed [24:0] jdn,
  output logic [4:0]         result_day,
  output logic [3:0]         result_month,
  output logic [13:0]        result_year,
  output logic               out_of_range
);
  import dovj_pkg::*;

  // Stage 1: range test and century numerator, biased by four centuries.
  logic               oor_nxt, oor1_r;
  logic signed [26:0] n1_w;
  logic [23:0]        n1_r;
  logic [22:0]        jd1_r;

  assign oor_nxt = (jdn < JDN_FIRST) || (jdn > JDN_LAST);
  assign n1_w    = $signed({jdn, 2'b00}) - 27'sd6884477;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      oor1_r <= oor_nxt;
      n1_r   <= n1_w[23:0];
      jd1_r  <= jdn[22:0];
    end
  end

  // Stage 2: century quotient.
  logic [48:0] pb;
  logic [6:0]  bq_r;
  logic [22:0] jd2_r;
  logic        oor2_r;

  assign pb = 49'(n1_r) * 49'(DIVB_RCP);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      bq_r   <= 7'(pb >> DIVB_SH);
      jd2_r  <= jd1_r;
      oor2_r <= oor1_r;
    end
  end

  // Stage 3: Gregorian correction and the numerator of the year quotient.
  logic signed [7:0]  bs, bfl;
  logic signed [24:0] dd_w;
  logic [22:0]        dd_nxt, dd3_r;
  logic [26:0]        u_nxt, u_r;
  logic               oor3_r;

  assign bs     = $signed({1'b0, bq_r}) - 8'sd4;
  assign bfl    = bs >>> 2;
  assign dd_w   = $signed({2'b0, jd2_r}) + 25'sd1525 + 25'(bs) - 25'(bfl);
  assign dd_nxt = dd_w[22:0];
  assign u_nxt  = 27'(dd_nxt) * 27'd20 - 27'd2442;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      dd3_r  <= dd_nxt;
      u_r    <= u_nxt;
      oor3_r <= oor2_r;
    end
  end

  // Stage 4: year quotient.
  logic [54:0] pe;
  logic [13:0] e4_r;
  logic [22:0] dd4_r;
  logic        oor4_r;

  assign pe = 55'(u_r) * 55'(DIVE_RCP);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      e4_r   <= 14'(pe >> DIVE_SH);
      dd4_r  <= dd3_r;
      oor4_r <= oor3_r;
    end
  end

  // Stage 5: days into the March-based year.
  logic [24:0] pf;
  logic [9:0]  h5_r;
  logic [13:0] e5_r;
  logic        oor5_r;

  assign pf = 25'(e4_r) * 25'(11'd1461);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      h5_r   <= 10'(dd4_r - pf[24:2]);
      e5_r   <= e4_r;
      oor5_r <= oor4_r;
    end
  end

  // Stage 6: month code from a threshold compare.
  logic [3:0]  g_nxt, g6_r;
  logic [9:0]  h6_r;
  logic [13:0] e6_r;
  logic        oor6_r;

  always_comb begin
    g_nxt = '0;
    for (int k = 1; k < 16; k++) begin
      if (h5_r >= G_THR[k]) begin
        g_nxt = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      g6_r   <= g_nxt;
      h6_r   <= h5_r;
      e6_r   <= e5_r;
      oor6_r <= oor5_r;
    end
  end

  // Stage 7: output register.
  logic [9:0]  rday_w;
  logic [3:0]  rmon_w;
  logic [13:0] ryr_w;
  logic [4:0]  rday_r;
  logic [3:0]  rmon_r;
  logic [13:0] ryr_r;
  logic        oor7_r;

  assign rday_w = h6_r - month_base(g6_r);
  assign rmon_w = (g6_r < 4'd14) ? g6_r - 4'd1 : g6_r - 4'd13;
  assign ryr_w  = (rmon_w > 4'd2) ? e6_r - 14'd4716 : e6_r - 14'd4715;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      oor7_r <= oor6_r;
      if (oor6_r) begin
        rday_r <= '0;
        rmon_r <= '0;
        ryr_r  <= '0;
      end else begin
        rday_r <= rday_w[4:0];
        rmon_r <= rmon_w;
        ryr_r  <= ryr_w;
      end
    end
  end

  assign result_day   = rday_r;
  assign result_month = rmon_r;
  assign result_year  = ryr_r;
  assign out_of_range = oor7_r;

endmodule

// ===== hdl/date_offset_via_julian_day_unit.sv =====
// ----------------------------------------------------------------------------
// date_offset_via_julian_day_unit: add a day offset to a Gregorian date
// Converts the start date to a Julian day number, adds the signed offset and
// converts back, proleptic Gregorian in both directions.
//
//   channel  ports                     contents
//   -------  ------------------------  ---------------------------------------
//   input    in_tvalid/tready/tdata    day, month, year, offset_days
//   result   out_tvalid/tready/tdata   result_day, result_month, result_year
//            out_tuser                 out_of_range
//
// One transfer per cycle sustained while out_tready is high; each item passes
// through the ten-stage pipeline (three forward stages, seven inverse stages).
// Every stage has its own valid bit, so bubbles close up while the output
// is stalled and the input keeps taking items until all stages are full.
// Reset clears the valid bits only; no reset sweep is needed.
// ----------------------------------------------------------------------------
module date_offset_via_julian_day_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] day, [8:5] month, [22:9] year, [45:23] offset_days, [47:46] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] result_day, [8:5] result_month, [22:9] result_year, [23] zero
  output logic [23:0] out_tdata,
  // [0] out_of_range
  output logic        out_tuser
);
  import dovj_pkg::*;

  logic [PIPE_STAGES-1:0] v_r, v_nxt;
  logic [PIPE_STAGES-1:0] adv;
  fwd_ld_t                fwd_ld;
  inv_ld_t                inv_ld;
  logic signed [24:0]     jdn;
  logic [4:0]             rday;
  logic [3:0]             rmon;
  logic [13:0]            ryr;
  logic                   oor;

  // A stage moves forward when it is empty or the stage after it moves.
  always_comb begin
    adv[PIPE_STAGES-1] = !v_r[PIPE_STAGES-1] || out_tready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    for (int k = 0; k < PIPE_STAGES; k++) begin
      if (adv[k]) begin
        v_nxt[k] = (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign fwd_ld    = adv[FWD_STAGES-1:0];
  assign inv_ld    = adv[PIPE_STAGES-1:FWD_STAGES];
  assign in_tready = adv[0];

  dovj_fwd u_fwd (
    .clk         (clk),
    .ld          (fwd_ld),
    .day         (in_tdata[4:0]),
    .month       (in_tdata[8:5]),
    .year        (in_tdata[22:9]),
    .offset_days ($signed(in_tdata[45:23])),
    .jdn         (jdn)
  );

  dovj_inv u_inv (
    .clk          (clk),
    .ld           (inv_ld),
    .jdn          (jdn),
    .result_day   (rday),
    .result_month (rmon),
    .result_year  (ryr),
    .out_of_range (oor)
  );

  assign out_tvalid = v_r[PIPE_STAGES-1];
  assign out_tdata  = {1'b0, ryr, rmon, rday};
  assign out_tuser  = oor;

`ifndef SYNTHESIS
  // The input is held off only when every stage holds an item.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input stalled while the pipeline has a free stage");

  // An out-of-range result carries an all-zero date.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("out-of-range result with a nonzero date");

  // An in-range result is always a real day and month.
  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (out_tdata[4:0] != 5'd0 && out_tdata[8:5] != 4'd0 && out_tdata[8:5] <= 4'd12))
    else $error("in-range result with an impossible day or month");
`endif

endmodule

// ===== test/date_offset_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_offset_checker: result checker for the date offset unit
// Watches both stream channels. For every input transfer it works out the
// shifted date on its own, using proleptic Gregorian day-number arithmetic
// in 64-bit integers. Every result transfer is compared field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module date_offset_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // [4:0] day, [8:5] month, [22:9] year, [45:23] offset_days, [47:46] zero
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] result_day, [8:5] result_month, [22:9] result_year, [23] zero
  input  logic [23:0] out_tdata,
  // [0] out_of_range
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending,
  output int          dates_checked,
  output int          range_hits
);

  // Day numbers of 0001-01-01 and 9999-12-31.
  localparam longint FIRST_DAY_NUMBER = 1721426;
  localparam longint LAST_DAY_NUMBER  = 5373484;

  // Laid out so that {out_tuser, out_tdata} maps onto it directly.
  typedef struct packed {
    logic        out_of_range;
    logic        pad;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } shifted_date_t;

  shifted_date_t expected_dates[$];

  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  // Forward conversion; January and February count as months 13 and 14 of
  // the year before. Malformed dates go through the same formula.
  function automatic longint day_number(longint d, longint m, longint y);
    longint cent;
    longint corr;
    if (m < 3) begin
      y = y - 1;
      m = m + 12;
    end
    cent = floor_quot(y, 100);
    corr = 2 - cent + floor_quot(cent, 4);
    return floor_quot(1461 * (y + 4716), 4) + floor_quot(306001 * (m + 1), 10000)
           + d + corr - 1524;
  endfunction

  function automatic shifted_date_t predict_shift(logic [47:0] word);
    logic signed [22:0] off;
    longint jd, b, c, dd, e, f, g, rd, rm, ry;
    shifted_date_t r;
    r = '0;
    off = word[45:23];
    jd = day_number(longint'(word[4:0]), longint'(word[8:5]), longint'(word[22:9]))
         + longint'(off);
    if (jd < FIRST_DAY_NUMBER || jd > LAST_DAY_NUMBER) begin
      r.out_of_range = 1'b1;
      return r;
    end
    b  = floor_quot(4 * jd - 7468865, 146097);
    c  = jd + 1 + b - floor_quot(b, 4);
    dd = c + 1524;
    e  = floor_quot(20 * dd - 2442, 7305);
    f  = floor_quot(1461 * e, 4);
    g  = floor_quot(10000 * (dd - f), 306001);
    rd = dd - f - floor_quot(306001 * g, 10000);
    rm = (g < 14) ? g - 1 : g - 13;
    ry = (rm > 2) ? e - 4716 : e - 4715;
    r.day   = 5'(rd);
    r.month = 4'(rm);
    r.year  = 14'(ry);
    return r;
  endfunction

  always @(posedge clk) begin : track
    shifted_date_t want;
    shifted_date_t got;
    int bad;
    if (!rst_n) begin
      expected_dates.delete();
      fail_count    <= 0;
      pending       <= 0;
      dates_checked <= 0;
      range_hits    <= 0;
    end else begin
      bad = 0;
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (expected_dates.size() == 0) begin
          $display("%0t: result with nothing outstanding: %h", $time, got);
          bad = 1;
        end else begin
          want = expected_dates.pop_front();
          if (got.out_of_range !== want.out_of_range) begin
            $display("%0t: out_of_range expected %0d got %0d", $time,
                     want.out_of_range, got.out_of_range);
            bad = 1;
          end
          if (got.day !== want.day) begin
            $display("%0t: result_day expected %0d got %0d", $time, want.day, got.day);
            bad = 1;
          end
          if (got.month !== want.month) begin
            $display("%0t: result_month expected %0d got %0d", $time,
                     want.month, got.month);
            bad = 1;
          end
          if (got.year !== want.year) begin
            $display("%0t: result_year expected %0d got %0d", $time,
                     want.year, got.year);
            bad = 1;
          end
          if (got.pad !== 1'b0) begin
            $display("%0t: tdata pad bit expected 0 got %b", $time, got.pad);
            bad = 1;
          end
          dates_checked <= dates_checked + 1;
          if (want.out_of_range) range_hits <= range_hits + 1;
        end
      end
      if (in_tvalid && in_tready) expected_dates.push_back(predict_shift(in_tdata));
      fail_count <= fail_count + bad;
      pending    <= expected_dates.size();
    end
  end

endmodule

// ===== test/date_offset_via_julian_day_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_offset_via_julian_day_unit_tb: testbench for the date offset unit
// Sends calendar edges, leap days, malformed dates and random offsets through
// the unit with random gaps on the input and random stalls on the output;
// the checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module date_offset_via_julian_day_unit_tb;
  import dovj_pkg::*;

  localparam int RUN_LIMIT    = 200000;
  localparam int RANDOM_ITEMS = 1250;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  int fail_count;
  int pending;
  int dates_checked;
  int range_hits;
  int cycle_count = 0;
  int rx_hold     = 0;
  int rx_draw;
  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;

  always #1 clk = ~clk;

  date_offset_via_julian_day_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  date_offset_checker shift_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .dates_checked(dates_checked),
    .range_hits   (range_hits)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // After each result transfer the receiver may hold off, by a random draw unless rx_steady is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
    end else if (rx_hold != 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= (rx_hold == 1);
    end else if (out_tready && out_tvalid) begin
      rx_draw = rx_steady ? 0 : $urandom_range(0, 3);
      rx_hold    <= rx_draw;
      out_tready <= (rx_draw == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [47:0] pack_item(int d, int m, int y, int off);
    return {2'b00, 23'(off), 14'(y), 4'(m), 5'(d)};
  endfunction

  function automatic int month_len(int m, int y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int signed_draw(int span);
    int mag;
    mag = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [47:0] random_item();
    int kind, pick, y, m, d, off;
    kind = $urandom_range(0, 99);
    y = $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, month_len(m, y));
    pick = $urandom_range(0, 2);
    off = (pick == 0) ? signed_draw(400) :
          (pick == 1) ? signed_draw(40000) : int'($signed(23'($urandom)));
    if (kind < 15) begin
      // Near either end of the supported range, crossing it now and then.
      if ($urandom_range(0, 1)) begin
        y = $urandom_range(1, 2);
      end else begin
        y = $urandom_range(9998, 9999);
      end
      d = $urandom_range(1, month_len(m, y));
      off = signed_draw(800);
    end else if (kind < 25) begin
      // Around the end of February in any year.
      m = 2;
      d = $urandom_range(27, month_len(2, y));
      off = signed_draw(3);
    end else if (kind < 40) begin
      // Malformed fields anywhere in their bit range.
      d = $urandom_range(0, 31);
      m = $urandom_range(0, 15);
      y = $urandom_range(0, 16383);
      off = int'($signed(23'($urandom)));
    end
    return pack_item(d, m, y, off);
  endfunction

  task automatic push_item(input logic [47:0] word);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // The outstanding count is registered, so look only after the next edge.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    push_item(pack_item(1, 1, 1, 0));
    push_item(pack_item(31, 12, 9999, 0));
    push_item(pack_item(1, 1, 1, -1));
    push_item(pack_item(31, 12, 9999, 1));
    push_item(pack_item(1, 1, 1, 3652058));
    push_item(pack_item(1, 1, 2000, 4194303));
    push_item(pack_item(31, 12, 9999, -4194304));
    push_item(pack_item(1, 1, 1, -4194304));
    push_item(pack_item(28, 2, 2000, 1));
    push_item(pack_item(28, 2, 1900, 1));
    push_item(pack_item(29, 2, 2024, 1));
    push_item(pack_item(1, 3, 1, -1));
    push_item(pack_item(1, 3, 400, -1));
    // No Julian-to-Gregorian cutover: the day after 4 October 1582 is the 5th.
    push_item(pack_item(4, 10, 1582, 1));
    push_item(pack_item(0, 3, 2023, 0));
    push_item(pack_item(31, 2, 2023, 0));
    push_item(pack_item(15, 0, 2023, 0));
    push_item(pack_item(15, 13, 2023, 0));
    push_item(pack_item(1, 1, 0, 0));
    push_item(pack_item(31, 15, 16383, -4194304));
    push_item(pack_item(31, 15, 16383, 4194303));
    push_item(pack_item(0, 0, 0, 4194303));
    wait_idle();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      tx_steady = ((i / 100) % 4 == 3);
      rx_steady <= ((i / 130) % 5 == 4);
      if (i == RANDOM_ITEMS / 2) wait_idle();
      push_item(random_item());
    end
    wait_idle();
    repeat (PIPE_STAGES + 4) @(posedge clk);

    $display("Compared %0d shifted dates, %0d of them flagged outside years 1 to 9999.",
             dates_checked, range_hits);
    $display("Stimulus spanned range ends, leap days, malformed dates and full-width offsets.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
